[design/tabi_pkg.sv]
// Package for the two-axis breakpoint interpolator.
// Shared types, codes and size constants; no dependencies.
package tabi_pkg;

  localparam int TABI_MAX_ROWS    = 8;
  localparam int TABI_MAX_COLUMNS = 8;
  localparam int TABI_QUEUE_DEPTH = 2;   // power of two
  localparam int TABI_CFG_AW      = 2;
  localparam int TABI_DIV_STEPS   = 17;

  typedef enum logic [1:0] {
    OP_WR_ROW = 2'd0,
    OP_WR_ENT = 2'd1,
    OP_QUERY  = 2'd2
  } op_t;

  typedef enum logic [1:0] {
    ST_OK        = 2'd0,
    ST_NO_ROWS   = 2'd1,
    ST_EMPTY_ROW = 2'd2
  } status_t;

  typedef enum logic [1:0] {
    K_ROW,
    K_ENT,
    K_QUERY
  } item_kind_t;

  typedef struct packed {
    item_kind_t         kind;
    logic [2:0]         row;
    logic [2:0]         col;
    logic [15:0]        distance;
    logic [3:0]         len;
    logic signed [15:0] height;
    logic signed [15:0] yaw;
    logic [15:0]        amt;
  } item_t;

  typedef struct packed {
    logic signed [16:0] a;
    logic signed [16:0] b;
    logic [15:0]        t;
    logic [15:0]        den;
  } mix_req_t;

  typedef struct packed {
    logic busy;
    logic done;
  } mix_stat_t;

  typedef enum logic [1:0] {
    M_IDLE,
    M_MUL,
    M_DIV,
    M_DONE
  } mix_state_t;

  typedef enum logic [1:0] {
    PH_FIRST,
    PH_LAST,
    PH_SCAN
  } phase_t;

  typedef enum logic [3:0] {
    B_IDLE,
    B_RD,
    B_CK,
    B_CHK_LO,
    B_CHK_HI,
    B_ROW,
    B_VLO,
    B_VLO_CK,
    B_VHI,
    B_VHI_CK,
    B_MY_GO,
    B_MY_WT,
    B_MA_GO,
    B_MA_WT,
    B_ROW_END,
    B_DONE
  } back_state_t;

endpackage

[design/tabi_if.sv]
// Channel interfaces for the interpolator: item input and result output.
// Valid/ready transfer; no package dependency.
interface tabi_in_if;
  logic               valid;
  logic               ready;
  logic [1:0]         op;
  logic [2:0]         row_index;
  logic [2:0]         column_index;
  logic [15:0]        row_distance;
  logic [3:0]         row_length;
  logic signed [15:0] entry_height;
  logic signed [15:0] entry_yaw;
  logic [15:0]        entry_amount;
  logic [15:0]        query_distance;
  logic signed [15:0] query_height;

  modport source(output valid, op, row_index, column_index, row_distance, row_length,
                 entry_height, entry_yaw, entry_amount, query_distance, query_height,
                 input ready);
  modport sink(input valid, op, row_index, column_index, row_distance, row_length,
               entry_height, entry_yaw, entry_amount, query_distance, query_height,
               output ready);
endinterface

interface tabi_out_if;
  logic               valid;
  logic               ready;
  logic signed [15:0] result_yaw;
  logic [15:0]        result_amount;
  logic [1:0]         status;

  modport source(output valid, result_yaw, result_amount, status, input ready);
  modport sink(input valid, result_yaw, result_amount, status, output ready);
endinterface

[design/tabi_front.sv]
// Front end: accepts, classifies and queues input transfers, but drops
// bad ops and out-of-range writes. Depends on tabi_pkg and tabi_in_if.
module tabi_front
  import tabi_pkg::*;
#(
  parameter int MAX_ROWS    = TABI_MAX_ROWS,
  parameter int MAX_COLUMNS = TABI_MAX_COLUMNS
) (
  input  logic       clk,
  input  logic       rst_n,
  tabi_in_if.sink    in_ch,
  output item_t      head,
  output logic       head_valid,
  input  logic       pop
);

  localparam int DEPTH = TABI_QUEUE_DEPTH;
  localparam int PW    = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CNTW  = $clog2(DEPTH + 1);

  item_t            q_r [DEPTH];
  logic [PW-1:0]    wr_ptr_r, rd_ptr_r;
  logic [CNTW-1:0]  count_r;
  item_t            item;
  logic             keep, push, row_ok, col_ok;

  assign row_ok = int'(in_ch.row_index) < MAX_ROWS;
  assign col_ok = int'(in_ch.column_index) < MAX_COLUMNS;

  always_comb begin
    item.row      = in_ch.row_index;
    item.col      = in_ch.column_index;
    item.len      = (int'(in_ch.row_length) > MAX_COLUMNS) ? 4'(MAX_COLUMNS)
                                                           : in_ch.row_length;
    item.yaw      = in_ch.entry_yaw;
    item.amt      = in_ch.entry_amount;
    item.kind     = K_QUERY;
    item.distance = in_ch.query_distance;
    item.height   = in_ch.query_height;
    keep          = 1'b0;
    unique case (in_ch.op)
      OP_WR_ROW: begin
        item.kind     = K_ROW;
        item.distance = in_ch.row_distance;
        keep          = row_ok;
      end
      OP_WR_ENT: begin
        item.kind   = K_ENT;
        item.height = in_ch.entry_height;
        keep        = row_ok && col_ok;
      end
      OP_QUERY: begin
        keep = 1'b1;
      end
      default: begin
        keep = 1'b0;
      end
    endcase
  end

  assign in_ch.ready = count_r < CNTW'(DEPTH);
  assign push        = in_ch.valid && in_ch.ready && keep;
  assign head        = q_r[rd_ptr_r];
  assign head_valid  = count_r != '0;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      if (push) wr_ptr_r <= wr_ptr_r + 1'b1;
      if (pop)  rd_ptr_r <= rd_ptr_r + 1'b1;
      count_r <= count_r + CNTW'(push) - CNTW'(pop);
    end
  end

  always_ff @(posedge clk) begin
    if (push) q_r[wr_ptr_r] <= item;
  end

endmodule

[design/tabi_mix.sv]
// Shared interpolation unit: a + (b - a) * t / den, quotient truncated toward zero.
// A multiply state, then a restoring divide one quotient bit per cycle. Uses tabi_pkg.
module tabi_mix
  import tabi_pkg::*;
(
  input  logic               clk,
  input  logic               rst_n,
  input  logic               start,
  input  mix_req_t           req,
  output mix_stat_t          stat,
  output logic signed [16:0] res
);

  localparam int CW = $clog2(TABI_DIV_STEPS);

  mix_state_t          state_r, state_nxt;
  logic signed [16:0]  a_r;
  logic                neg_r;
  logic [16:0]         mag_r, dvd_r, q_r;
  logic [15:0]         t_r, den_r, rem_r;
  logic [CW-1:0]       cnt_r;
  logic signed [17:0]  diff, qs, sum;
  logic [32:0]         prod;
  logic [16:0]         rem2;
  logic                ge;

  assign diff = {req.b[16], req.b} - {req.a[16], req.a};
  assign prod = mag_r * t_r;
  assign rem2 = {rem_r, dvd_r[16]};
  assign ge   = rem2 >= {1'b0, den_r};
  assign qs   = neg_r ? -$signed({1'b0, q_r}) : $signed({1'b0, q_r});
  assign sum  = {a_r[16], a_r} + qs;

  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      M_IDLE: if (start) state_nxt = M_MUL;
      M_MUL:  state_nxt = M_DIV;
      M_DIV:  if (cnt_r == CW'(TABI_DIV_STEPS - 1)) state_nxt = M_DONE;
      M_DONE: state_nxt = M_IDLE;
      default: state_nxt = M_IDLE;
    endcase
  end

  always_comb begin
    stat.busy = state_r != M_IDLE;
    stat.done = state_r == M_DONE;
    res       = sum[16:0];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) state_r <= M_IDLE;
    else        state_r <= state_nxt;
  end

  always_ff @(posedge clk) begin
    unique case (state_r)
      M_IDLE: begin
        if (start) begin
          a_r   <= req.a;
          neg_r <= diff[17];
          mag_r <= diff[17] ? 17'(-diff) : diff[16:0];
          t_r   <= req.t;
          den_r <= req.den;
        end
      end
      M_MUL: begin
        rem_r <= prod[32:17];
        dvd_r <= prod[16:0];
        cnt_r <= '0;
      end
      M_DIV: begin
        rem_r <= ge ? 16'(rem2 - {1'b0, den_r}) : rem2[15:0];
        q_r   <= {q_r[15:0], ge};
        dvd_r <= {dvd_r[15:0], 1'b0};
        cnt_r <= cnt_r + 1'b1;
      end
      default: begin
      end
    endcase
  end

endmodule

[design/tabi_back.sv]
// Back end: table stores, breakpoint search sequencer and result register.
// Depends on tabi_pkg, tabi_out_if and tabi_mix.
module tabi_back
  import tabi_pkg::*;
#(
  parameter int MAX_ROWS    = TABI_MAX_ROWS,
  parameter int MAX_COLUMNS = TABI_MAX_COLUMNS
) (
  input  logic        clk,
  input  logic        rst_n,
  input  item_t       head,
  input  logic        head_valid,
  output logic        pop,
  input  logic [3:0]  entry_count,
  tabi_out_if.source  out_ch
);

  localparam int RW = (MAX_ROWS > 1) ? $clog2(MAX_ROWS) : 1;
  localparam int CW = (MAX_COLUMNS > 1) ? $clog2(MAX_COLUMNS) : 1;
  localparam int SW = (RW > CW) ? RW : CW;
  localparam int NW = SW + 1;
  localparam int ENTRIES = MAX_ROWS * MAX_COLUMNS;
  localparam int AW = (ENTRIES > 1) ? $clog2(ENTRIES) : 1;

  // table stores
  logic [15:0]  row_bp_mem [MAX_ROWS];
  logic [47:0]  ent_mem [ENTRIES];
  logic [3:0]   rowlen_r [MAX_ROWS];
  logic [15:0]  row_bp_q;
  logic [47:0]  ent_q;

  back_state_t         state_r, state_nxt;
  phase_t              phase_r;
  logic                lvl_dist_r, pass_r;
  logic [SW-1:0]       idx_r, s_lo_r, s_hi_r;
  logic [NW-1:0]       n_r, nrows;
  logic signed [16:0]  v_r, prev_k_r, sk_lo_r, sk_hi_r, key;
  logic [RW-1:0]       d_lo_r, d_hi_r, row_cur_r, len_addr;
  logic [15:0]         dk_lo_r, dk_hi_r, qd_r, t_r, den_r;
  logic signed [15:0]  qh_r;
  logic signed [16:0]  va_y_r, vb_y_r, va_a_r, vb_a_r, ry_r, ra_r, y0_r, a0_r;
  logic signed [16:0]  hdiff_t, hdiff_d;
  status_t             st_r;
  logic                out_valid_r;
  logic signed [15:0]  out_yaw_r;
  logic [15:0]         out_amt_r;
  status_t             out_st_r;

  logic                found, row_we, ent_we, mix_start, load_out;
  logic [3:0]          len_rd;
  logic [RW-1:0]       row_rd_addr, row_wr_addr;
  logic [AW-1:0]       ent_rd_addr, ent_wr_addr;
  mix_req_t            mix_req;
  mix_stat_t           mstat;
  logic signed [16:0]  mres;

  tabi_mix u_mix (
    .clk   (clk),
    .rst_n (rst_n),
    .start (mix_start),
    .req   (mix_req),
    .stat  (mstat),
    .res   (mres)
  );

  assign row_rd_addr = RW'(idx_r);
  assign row_wr_addr = RW'(head.row);
  assign ent_rd_addr = AW'(int'(row_cur_r) * MAX_COLUMNS + int'(idx_r[CW-1:0]));
  assign ent_wr_addr = AW'(int'(head.row) * MAX_COLUMNS + int'(head.col));

  always_ff @(posedge clk) begin
    if (row_we) row_bp_mem[row_wr_addr] <= head.distance;
    row_bp_q <= row_bp_mem[row_rd_addr];
  end

  always_ff @(posedge clk) begin
    if (ent_we) ent_mem[ent_wr_addr] <= {head.height, head.yaw, head.amt};
    ent_q <= ent_mem[ent_rd_addr];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int i = 0; i < MAX_ROWS; i++) rowlen_r[i] <= '0;
    end else if (row_we) begin
      rowlen_r[row_wr_addr] <= head.len;
    end
  end

  assign len_rd  = rowlen_r[len_addr];
  assign nrows   = (int'(entry_count) > MAX_ROWS) ? NW'(MAX_ROWS) : NW'(entry_count);
  assign key     = lvl_dist_r ? $signed({1'b0, row_bp_q}) : $signed({ent_q[47], ent_q[47:32]});
  assign hdiff_t = $signed({qh_r[15], qh_r}) - sk_lo_r;
  assign hdiff_d = sk_hi_r - sk_lo_r;

  always_comb begin
    unique case (phase_r)
      PH_FIRST: found = (n_r == NW'(1)) || (v_r <= key);
      PH_LAST:  found = v_r >= key;
      PH_SCAN:  found = key >= v_r;
      default:  found = 1'b1;
    endcase
  end

  // next state
  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      B_IDLE: begin
        if (head_valid && head.kind == K_QUERY)
          state_nxt = (nrows == '0) ? B_DONE : B_RD;
      end
      B_RD:     state_nxt = B_CK;
      B_CK: begin
        if (found) state_nxt = lvl_dist_r ? B_CHK_LO : B_VLO;
        else       state_nxt = B_RD;
      end
      B_CHK_LO: state_nxt = (len_rd == '0) ? B_DONE : B_CHK_HI;
      B_CHK_HI: state_nxt = (d_lo_r != d_hi_r && len_rd == '0) ? B_DONE : B_ROW;
      B_ROW:    state_nxt = B_RD;
      B_VLO:    state_nxt = B_VLO_CK;
      B_VLO_CK: state_nxt = B_VHI;
      B_VHI:    state_nxt = B_VHI_CK;
      B_VHI_CK: state_nxt = (s_lo_r == s_hi_r) ? B_ROW_END : B_MY_GO;
      B_MY_GO:  state_nxt = B_MY_WT;
      B_MY_WT:  if (mstat.done) state_nxt = B_MA_GO;
      B_MA_GO:  state_nxt = B_MA_WT;
      B_MA_WT:  if (mstat.done) state_nxt = lvl_dist_r ? B_DONE : B_ROW_END;
      B_ROW_END: begin
        if (!pass_r) state_nxt = (d_lo_r == d_hi_r) ? B_DONE : B_ROW;
        else         state_nxt = B_MY_GO;
      end
      B_DONE:   if (!out_valid_r || out_ch.ready) state_nxt = B_IDLE;
      default:  state_nxt = B_IDLE;
    endcase
  end

  // outputs
  always_comb begin
    pop       = (state_r == B_IDLE) && head_valid;
    row_we    = pop && head.kind == K_ROW;
    ent_we    = pop && head.kind == K_ENT;
    mix_start = (state_r == B_MY_GO) || (state_r == B_MA_GO);
    load_out  = (state_r == B_DONE) && (!out_valid_r || out_ch.ready);
    mix_req.t   = t_r;
    mix_req.den = den_r;
    mix_req.a   = (state_r == B_MA_GO) ? va_a_r : va_y_r;
    mix_req.b   = (state_r == B_MA_GO) ? vb_a_r : vb_y_r;
    unique case (state_r)
      B_CHK_LO: len_addr = d_lo_r;
      B_CHK_HI: len_addr = d_hi_r;
      default:  len_addr = row_cur_r;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= B_IDLE;
      out_valid_r <= 1'b0;
    end else begin
      state_r <= state_nxt;
      if (load_out)          out_valid_r <= 1'b1;
      else if (out_ch.ready) out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (load_out) begin
      out_yaw_r <= ry_r[15:0];
      out_amt_r <= ra_r[15:0];
      out_st_r  <= st_r;
    end
  end

  always_ff @(posedge clk) begin
    unique case (state_r)
      B_IDLE: begin
        if (head_valid && head.kind == K_QUERY) begin
          qd_r       <= head.distance;
          qh_r       <= head.height;
          st_r       <= ST_OK;
          ry_r       <= '0;
          ra_r       <= '0;
          n_r        <= nrows;
          v_r        <= $signed({1'b0, head.distance});
          idx_r      <= '0;
          phase_r    <= PH_FIRST;
          lvl_dist_r <= 1'b1;
          if (nrows == '0) st_r <= ST_NO_ROWS;
        end
      end
      B_CK: begin
        unique case (phase_r)
          PH_FIRST: begin
            if (found) begin
              s_lo_r <= '0; s_hi_r <= '0; sk_lo_r <= key; sk_hi_r <= key;
              if (lvl_dist_r) begin
                d_lo_r <= '0; d_hi_r <= '0; dk_lo_r <= key[15:0]; dk_hi_r <= key[15:0];
              end
              idx_r  <= '0;
            end else begin
              prev_k_r <= key;
              phase_r  <= PH_LAST;
              idx_r    <= SW'(n_r - 1'b1);
            end
          end
          PH_LAST: begin
            if (found) begin
              s_lo_r <= idx_r; s_hi_r <= idx_r; sk_lo_r <= key; sk_hi_r <= key;
              if (lvl_dist_r) begin
                d_lo_r <= RW'(idx_r); d_hi_r <= RW'(idx_r);
                dk_lo_r <= key[15:0]; dk_hi_r <= key[15:0];
              end
            end else begin
              phase_r <= PH_SCAN;
              idx_r   <= SW'(1);
            end
          end
          default: begin
            if (found) begin
              s_lo_r <= idx_r - 1'b1; s_hi_r <= idx_r;
              sk_lo_r <= prev_k_r; sk_hi_r <= key;
              if (lvl_dist_r) begin
                d_lo_r <= RW'(idx_r - 1'b1); d_hi_r <= RW'(idx_r);
                dk_lo_r <= prev_k_r[15:0]; dk_hi_r <= key[15:0];
              end
              idx_r  <= idx_r - 1'b1;
            end else begin
              prev_k_r <= key;
              idx_r    <= idx_r + 1'b1;
            end
          end
        endcase
      end
      B_CHK_LO: if (len_rd == '0) st_r <= ST_EMPTY_ROW;
      B_CHK_HI: begin
        if (d_lo_r != d_hi_r && len_rd == '0) st_r <= ST_EMPTY_ROW;
        row_cur_r <= d_lo_r;
        pass_r    <= 1'b0;
      end
      B_ROW: begin
        n_r        <= NW'(len_rd);
        v_r        <= $signed({qh_r[15], qh_r});
        idx_r      <= '0;
        phase_r    <= PH_FIRST;
        lvl_dist_r <= 1'b0;
      end
      B_VLO_CK: begin
        va_y_r <= $signed({ent_q[31], ent_q[31:16]});
        va_a_r <= $signed({1'b0, ent_q[15:0]});
        idx_r  <= s_hi_r;
      end
      B_VHI_CK: begin
        vb_y_r <= $signed({ent_q[31], ent_q[31:16]});
        vb_a_r <= $signed({1'b0, ent_q[15:0]});
        t_r    <= hdiff_t[15:0];
        den_r  <= hdiff_d[15:0];
        if (s_lo_r == s_hi_r) begin
          ry_r <= va_y_r;
          ra_r <= va_a_r;
        end
      end
      B_MY_WT: if (mstat.done) ry_r <= mres;
      B_MA_WT: if (mstat.done) ra_r <= mres;
      B_ROW_END: begin
        if (!pass_r) begin
          y0_r      <= ry_r;
          a0_r      <= ra_r;
          pass_r    <= 1'b1;
          row_cur_r <= d_hi_r;
        end else begin
          va_y_r     <= y0_r;
          vb_y_r     <= ry_r;
          va_a_r     <= a0_r;
          vb_a_r     <= ra_r;
          t_r        <= qd_r - dk_lo_r;
          den_r      <= dk_hi_r - dk_lo_r;
          lvl_dist_r <= 1'b1;
        end
      end
      default: begin
      end
    endcase
  end

  assign out_ch.valid         = out_valid_r;
  assign out_ch.result_yaw    = out_yaw_r;
  assign out_ch.result_amount = out_amt_r;
  assign out_ch.status        = out_st_r;

`ifndef SYNTHESIS
  a_mix_start_idle: assert property (@(posedge clk) disable iff (!rst_n)
    mix_start |-> !mstat.busy) else $error("mix unit started while busy");

  a_probe_in_range: assert property (@(posedge clk) disable iff (!rst_n)
    state_r == B_CK |-> {1'b0, idx_r} < n_r) else $error("probe index past table end");

  a_load_from_done: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_valid_r) |-> $past(state_r) == B_DONE) else $error("result loaded early");

  a_error_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r && out_st_r != ST_OK |-> out_yaw_r == '0 && out_amt_r == '0)
    else $error("error result carries data");
`endif

endmodule

[design/two_axis_breakpoint_interpolator.sv]
// Two-axis breakpoint interpolator. A table write leaves the queue as soon as it is at
// its head while the sequencer is idle. A query ends early when there are no distance
// rows or a selected row is empty. Otherwise its duration is set by the breakpoint probes
// through the registered table memories and by the single shared multiply/divide unit,
// which runs up to six interpolations per query. A two-entry queue keeps accepting items
// while a query runs until it is full, and the result register holds a finished result
// until taken.
// Depends on tabi_pkg, tabi_if, tabi_front and tabi_back.
module two_axis_breakpoint_interpolator
  import tabi_pkg::*;
#(
  parameter int MAX_ROWS    = TABI_MAX_ROWS,
  parameter int MAX_COLUMNS = TABI_MAX_COLUMNS
) (
  input  logic                   clk,
  input  logic                   rst_n,
  tabi_in_if.sink                in_ch,
  tabi_out_if.source             out_ch,
  input  logic                   cfg_psel,
  input  logic                   cfg_penable,
  input  logic                   cfg_pwrite,
  input  logic [TABI_CFG_AW-1:0] cfg_paddr,
  input  logic [31:0]            cfg_pwdata,
  output logic [31:0]            cfg_prdata,
  output logic                   cfg_pready
);

  logic [3:0] entry_count_r;
  item_t      head;
  logic       head_valid, pop;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      entry_count_r <= '0;
    end else if (cfg_psel && cfg_penable && cfg_pwrite) begin
      entry_count_r <= cfg_pwdata[3:0];
    end
  end

  assign cfg_pready = 1'b1;
  assign cfg_prdata = (cfg_paddr == '0) ? {28'd0, entry_count_r} : {28'd0, entry_count_r};

  tabi_front #(
    .MAX_ROWS    (MAX_ROWS),
    .MAX_COLUMNS (MAX_COLUMNS)
  ) u_front (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_ch      (in_ch),
    .head       (head),
    .head_valid (head_valid),
    .pop        (pop)
  );

  tabi_back #(
    .MAX_ROWS    (MAX_ROWS),
    .MAX_COLUMNS (MAX_COLUMNS)
  ) u_back (
    .clk         (clk),
    .rst_n       (rst_n),
    .head        (head),
    .head_valid  (head_valid),
    .pop         (pop),
    .entry_count (entry_count_r),
    .out_ch      (out_ch)
  );

endmodule

[tb/tb_two_axis_breakpoint_interpolator.sv]
`timescale 1ns / 100ps
// Testbench for two_axis_breakpoint_interpolator: loads breakpoint tables, queries them
// and checks each result against a scoreboard that predicts the lookup.
// Depends on tabi_pkg, tabi_if and the block's RTL.
module tb_two_axis_breakpoint_interpolator;
  import tabi_pkg::*;

  localparam logic [1:0] OP_NONE = 2'd3;
  localparam logic [TABI_CFG_AW-1:0] REG_DIST_COUNT = '0;
  localparam int CYCLE_LIMIT = 3000000;
  localparam int SETTLE_CYCLES = 400;

  typedef struct {
    logic [1:0]         op;
    logic [2:0]         row;
    logic [2:0]         col;
    logic [15:0]        row_dist;
    logic [3:0]         len;
    logic signed [15:0] height;
    logic signed [15:0] yaw;
    logic [15:0]        amt;
    logic [15:0]        q_dist;
    logic signed [15:0] q_height;
  } tb_item_t;

  typedef struct {
    logic signed [15:0] yaw;
    logic [15:0]        amt;
    logic [1:0]         status;
  } lookup_t;

  class tabi_scoreboard;
    logic [15:0]        row_bp[8];
    logic [3:0]         row_len[8];
    logic signed [15:0] ent_h[64];
    logic signed [15:0] ent_y[64];
    logic [15:0]        ent_a[64];
    logic [3:0]         row_count;
    lookup_t            pending[$];
    int                 errors;

    function new();
      for (int i = 0; i < 8; i++) begin
        row_bp[i] = '0;
        row_len[i] = '0;
      end
      for (int i = 0; i < 64; i++) begin
        ent_h[i] = '0;
        ent_y[i] = '0;
        ent_a[i] = '0;
      end
      row_count = '0;
      errors = 0;
    endfunction

    function void set_row_count(logic [3:0] v);
      row_count = v;
    endfunction

    function void find_pair(longint keys[8], int n, longint v, output int lo, output int hi);
      int i;
      i = 0;
      if (n <= 1 || v <= keys[0]) begin
        lo = 0;
        hi = 0;
      end else if (v >= keys[n-1]) begin
        lo = n - 1;
        hi = n - 1;
      end else begin
        while (i < n - 1 && keys[i] < v) i++;
        lo = i - 1;
        hi = i;
      end
    endfunction

    function longint blend(longint ina, longint inb, longint v, longint outa, longint outb);
      longint num, den;
      if (ina == inb) return outa;
      num = (outb - outa) * (v - ina);
      den = inb - ina;
      if (den < 0) begin
        den = -den;
        num = -num;
      end
      return outa + num / den;
    endfunction

    function void blend_row(int r, int n, longint h, output longint y, output longint a);
      longint keys[8];
      int lo, hi;
      for (int k = 0; k < 8; k++) keys[k] = (k < n) ? longint'(ent_h[r*8+k]) : 0;
      find_pair(keys, n, h, lo, hi);
      y = blend(keys[lo], keys[hi], h, longint'(ent_y[r*8+lo]), longint'(ent_y[r*8+hi]));
      a = blend(keys[lo], keys[hi], h, longint'(ent_a[r*8+lo]), longint'(ent_a[r*8+hi]));
    endfunction

    function lookup_t predict_lookup(tb_item_t it);
      lookup_t r;
      longint keys[8];
      longint d, h, y0, a0, y1, a1, y, a;
      int n, lo, hi;
      d = longint'(it.q_dist);
      h = longint'(it.q_height);
      y = 0;
      a = 0;
      r.status = ST_OK;
      n = (int'(row_count) > 8) ? 8 : int'(row_count);
      if (n == 0) begin
        r.status = ST_NO_ROWS;
      end else begin
        for (int k = 0; k < 8; k++) keys[k] = (k < n) ? longint'(row_bp[k]) : 0;
        find_pair(keys, n, d, lo, hi);
        if (row_len[lo] == 0 || (keys[lo] != keys[hi] && row_len[hi] == 0)) begin
          r.status = ST_EMPTY_ROW;
        end else if (keys[lo] == keys[hi]) begin
          blend_row(lo, int'(row_len[lo]), h, y, a);
        end else begin
          blend_row(lo, int'(row_len[lo]), h, y0, a0);
          blend_row(hi, int'(row_len[hi]), h, y1, a1);
          y = blend(keys[lo], keys[hi], d, y0, y1);
          a = blend(keys[lo], keys[hi], d, a0, a1);
        end
      end
      r.yaw = y[15:0];
      r.amt = a[15:0];
      return r;
    endfunction

    function void note_input(tb_item_t it);
      case (it.op)
        OP_WR_ROW: begin
          row_bp[it.row] = it.row_dist;
          row_len[it.row] = (it.len > 8) ? 4'd8 : it.len;
        end
        OP_WR_ENT: begin
          ent_h[it.row*8+it.col] = it.height;
          ent_y[it.row*8+it.col] = it.yaw;
          ent_a[it.row*8+it.col] = it.amt;
        end
        OP_QUERY: pending.push_back(predict_lookup(it));
        default: ;
      endcase
    endfunction

    function void check_result(logic signed [15:0] yaw, logic [15:0] amt, logic [1:0] st);
      lookup_t e;
      if (pending.size() == 0) begin
        errors++;
        if (errors <= 10) $display("unexpected result yaw=%0d amt=%0d status=%0d", yaw, amt, st);
        return;
      end
      e = pending.pop_front();
      if (yaw !== e.yaw || amt !== e.amt || st !== e.status) begin
        errors++;
        if (errors <= 10)
          $display("mismatch: expected yaw=%0d amt=%0d status=%0d, got yaw=%0d amt=%0d status=%0d",
                   e.yaw, e.amt, e.status, yaw, amt, st);
      end
    endfunction
  endclass

  logic clk;
  logic rst_n;
  logic cfg_psel, cfg_penable, cfg_pwrite;
  logic [TABI_CFG_AW-1:0] cfg_paddr;
  logic [31:0] cfg_pwdata, cfg_prdata;
  logic cfg_pready;

  tabi_in_if  in_if();
  tabi_out_if out_if();

  two_axis_breakpoint_interpolator u_dut (
    .clk(clk), .rst_n(rst_n), .in_ch(in_if), .out_ch(out_if),
    .cfg_psel(cfg_psel), .cfg_penable(cfg_penable), .cfg_pwrite(cfg_pwrite),
    .cfg_paddr(cfg_paddr), .cfg_pwdata(cfg_pwdata), .cfg_prdata(cfg_prdata),
    .cfg_pready(cfg_pready)
  );

  tabi_scoreboard sb = new();
  int send_idle_pct = 0;
  int recv_stall_pct = 0;
  int hold_request = 0;
  int hold_left = 0;
  int cycles = 0;

  initial begin
    clk = 0;
    forever #4 clk = ~clk;
  end

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles > CYCLE_LIMIT) begin
      $display("Verification failed");
      $finish;
    end
  end

  // receiver: random stalls, plus a long hold-off on request
  always @(posedge clk) begin
    if (!rst_n) begin
      out_if.ready <= 1'b0;
    end else if (hold_left > 0) begin
      out_if.ready <= 1'b0;
      hold_left = hold_left - 1;
    end else if (hold_request > 0) begin
      out_if.ready <= 1'b0;
      hold_left = hold_request;
      hold_request = 0;
    end else begin
      out_if.ready <= ($urandom_range(99) >= recv_stall_pct);
    end
  end

  always @(posedge clk) begin
    tb_item_t it;
    if (rst_n && in_if.valid && in_if.ready) begin
      it.op = in_if.op;
      it.row = in_if.row_index;
      it.col = in_if.column_index;
      it.row_dist = in_if.row_distance;
      it.len = in_if.row_length;
      it.height = in_if.entry_height;
      it.yaw = in_if.entry_yaw;
      it.amt = in_if.entry_amount;
      it.q_dist = in_if.query_distance;
      it.q_height = in_if.query_height;
      sb.note_input(it);
    end
    if (rst_n && out_if.valid && out_if.ready)
      sb.check_result(out_if.result_yaw, out_if.result_amount, out_if.status);
  end

  task automatic send_item(tb_item_t it);
    in_if.valid <= 1'b1;
    in_if.op <= it.op;
    in_if.row_index <= it.row;
    in_if.column_index <= it.col;
    in_if.row_distance <= it.row_dist;
    in_if.row_length <= it.len;
    in_if.entry_height <= it.height;
    in_if.entry_yaw <= it.yaw;
    in_if.entry_amount <= it.amt;
    in_if.query_distance <= it.q_dist;
    in_if.query_height <= it.q_height;
    @(posedge clk);
    while (!in_if.ready) @(posedge clk);
    if ($urandom_range(99) < send_idle_pct) begin
      in_if.valid <= 1'b0;
      repeat ($urandom_range(1, 6)) @(posedge clk);
    end
  endtask

  function automatic tb_item_t blank_item(logic [1:0] op);
    tb_item_t it;
    it.op = op;
    it.row = 3'($urandom_range(7));
    it.col = 3'($urandom_range(7));
    it.row_dist = 16'($urandom);
    it.len = 4'($urandom_range(15));
    it.height = 16'($urandom);
    it.yaw = 16'($urandom);
    it.amt = 16'($urandom);
    it.q_dist = 16'($urandom);
    it.q_height = 16'($urandom);
    return it;
  endfunction

  task automatic write_row(int r, logic [15:0] d, logic [3:0] len);
    tb_item_t it;
    it = blank_item(OP_WR_ROW);
    it.row = 3'(r);
    it.row_dist = d;
    it.len = len;
    send_item(it);
  endtask

  task automatic query(logic [15:0] d, logic signed [15:0] h);
    tb_item_t it;
    it = blank_item(OP_QUERY);
    it.q_dist = d;
    it.q_height = h;
    send_item(it);
  endtask

  // ascending heights with random values; step zero now and then gives equal breakpoints
  task automatic fill_row_entries(int r);
    tb_item_t it;
    int hgt;
    hgt = -32768 + $urandom_range(20000);
    for (int c = 0; c < 8; c++) begin
      it = blank_item(OP_WR_ENT);
      it.row = 3'(r);
      it.col = 3'(c);
      it.height = 16'(hgt);
      send_item(it);
      hgt = hgt + (($urandom_range(9) == 0) ? 0 : $urandom_range(1, 7000));
      if (hgt > 32767) hgt = 32767;
    end
  endtask

  task automatic build_table();
    int d;
    d = $urandom_range(3000);
    for (int r = 0; r < 8; r++) begin
      fill_row_entries(r);
      write_row(r, 16'(d), 4'($urandom_range(1, 8)));
      d = d + (($urandom_range(11) == 0) ? 0 : $urandom_range(1, 8000));
      if (d > 65535) d = 65535;
    end
  endtask

  task automatic stop_sending();
    in_if.valid <= 1'b0;
    @(posedge clk);
  endtask

  task automatic drain();
    stop_sending();
    while (sb.pending.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic cfg_write(logic [TABI_CFG_AW-1:0] addr, logic [31:0] data);
    cfg_psel <= 1'b1;
    cfg_penable <= 1'b0;
    cfg_pwrite <= 1'b1;
    cfg_paddr <= addr;
    cfg_pwdata <= data;
    @(posedge clk);
    cfg_penable <= 1'b1;
    @(posedge clk);
    while (!cfg_pready) @(posedge clk);
    if (addr == REG_DIST_COUNT) sb.set_row_count(data[3:0]);
    cfg_psel <= 1'b0;
    cfg_penable <= 1'b0;
    cfg_pwrite <= 1'b0;
    @(posedge clk);
  endtask

  task automatic random_query();
    int r, c;
    int d, h;
    r = $urandom_range(7);
    c = $urandom_range(7);
    d = ($urandom_range(3) == 0) ? $urandom_range(65535)
                                 : int'(sb.row_bp[r]) + $urandom_range(400) - 200;
    h = ($urandom_range(3) == 0) ? int'($signed(16'($urandom)))
                                 : int'(sb.ent_h[r*8+c]) + $urandom_range(400) - 200;
    if (d < 0) d = 0;
    if (d > 65535) d = 65535;
    if (h < -32768) h = -32768;
    if (h > 32767) h = 32767;
    query(16'(d), 16'(h));
  endtask

  task automatic random_item();
    int pick;
    pick = $urandom_range(99);
    if (pick < 60) begin
      random_query();
    end else if (pick < 70) begin
      send_item(blank_item(OP_WR_ENT));
    end else if (pick < 77) begin
      write_row($urandom_range(7), 16'($urandom), 4'($urandom_range(15)));
    end else if (pick < 80) begin
      write_row($urandom_range(7), sb.row_bp[$urandom_range(7)], 4'($urandom_range(1, 8)));
    end else if (pick < 83) begin
      send_item(blank_item(OP_NONE));
    end else if (pick < 86) begin
      fill_row_entries($urandom_range(7));
    end else if (pick < 87) begin
      build_table();
    end else begin
      random_query();
    end
  endtask

  initial begin
    int counts[8] = '{8, 15, 1, 2, 8, 5, 9, 8};
    rst_n = 1'b0;
    in_if.valid = 1'b0;
    in_if.op = OP_WR_ROW;
    in_if.row_index = '0;
    in_if.column_index = '0;
    in_if.row_distance = '0;
    in_if.row_length = '0;
    in_if.entry_height = '0;
    in_if.entry_yaw = '0;
    in_if.entry_amount = '0;
    in_if.query_distance = '0;
    in_if.query_height = '0;
    cfg_psel = 1'b0;
    cfg_penable = 1'b0;
    cfg_pwrite = 1'b0;
    cfg_paddr = '0;
    cfg_pwdata = '0;
    repeat (6) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // empty table
    query(16'h1234, -16'sd5);
    build_table();
    drain();
    cfg_write(REG_DIST_COUNT, 32'd8);

    query(16'd0, 16'sh8000);
    query(16'hFFFF, 16'sd32767);
    query(sb.row_bp[3], sb.ent_h[3*8+2]);
    query(sb.row_bp[3] + ((sb.row_bp[4] - sb.row_bp[3]) >> 1), 16'sd0);
    write_row(2, sb.row_bp[2], 4'd0);
    query(sb.row_bp[2], 16'sd100);
    query(16'(sb.row_bp[1] + 16'd1), 16'sd100);
    write_row(2, sb.row_bp[2], 4'd15);
    query(sb.row_bp[2], 16'sd100);
    write_row(4, sb.row_bp[3], 4'd8);
    query(sb.row_bp[3], 16'sd0);
    query(16'(sb.row_bp[3] + 16'd1), 16'sd0);
    write_row(5, 16'd0, 4'd8);
    query(16'(sb.row_bp[4] + 16'd2), 16'sd7);
    send_item(blank_item(OP_NONE));
    build_table();
    drain();
    cfg_write(REG_DIST_COUNT, 32'd0);
    query(16'd100, 16'sd0);
    drain();

    for (int ph = 0; ph < 8; ph++) begin
      cfg_write(REG_DIST_COUNT, 32'(counts[ph]));
      case (ph % 4)
        0: begin send_idle_pct = 0; recv_stall_pct = 0; end
        1: begin send_idle_pct = 62; recv_stall_pct = 0; end
        2: begin send_idle_pct = 0; recv_stall_pct = 62; end
        default: begin send_idle_pct = 31; recv_stall_pct = 31; end
      endcase
      if (ph == 4) hold_request = 3000;
      for (int n = 0; n < 48; n++) random_item();
      drain();
    end

    if (sb.errors == 0 && sb.pending.size() == 0) begin
      $display("Verification passed");
    end else begin
      $display("Verification failed");
    end
    $finish;
  end

endmodule

[sim.f]
design/tabi_pkg.sv
design/tabi_if.sv
design/tabi_front.sv
design/tabi_mix.sv
design/tabi_back.sv
design/two_axis_breakpoint_interpolator.sv
tb/tb_two_axis_breakpoint_interpolator.sv
